// ===== rtl/neh_pkg.sv =====
// ----------------------------------------------------------------------------
// neh_pkg
// shared constants and controller/datapath interface structs
// ----------------------------------------------------------------------------
package neh_pkg;

    localparam int DEF_MAX_TASKS  = 32;
    localparam int DEF_VALUE_BITS = 16;
    localparam int DATA_W         = 16;

    // datapath commands, one per controller step
    typedef struct packed {
        logic load;      // store arriving task
        logic load_last; // final task of the set
        logic rk_rd_i;   // read task i for ranking
        logic rk_lat;    // latch key of task i
        logic rk_rd_j;   // read task j for ranking
        logic rk_cmp;    // compare keys, advance j
        logic rk_wr;     // write rank slot, advance i
        logic n0_rd;     // read first sorted entry
        logic n0_wr;     // seed the sequence
        logic cd_rd;     // read next candidate index
        logic cd_idx;    // latch candidate index, read its data
        logic cd_tw;     // latch candidate data
        logic tr_init;   // start one trial
        logic tr_ord;    // fetch sequence entry or pick candidate
        logic tr_oidx;   // read data of sequence entry
        logic tr_run;    // advance running time
        logic tr_mul;    // weight product
        logic tr_acc;    // accumulate cost
        logic tr_cmp;    // keep best position
        logic sh_rd;     // read entry below shift point
        logic sh_wr;     // move entry up one slot
        logic sh_ins;    // insert candidate
        logic em_ord;    // read sequence entry for output
        logic em_idx;    // read its task data
        logic em_out;    // present one result
    } cmd_t;

    typedef struct packed {
        logic j_last;    // ranking scan at final task
        logic i_last;    // outer index at final task
        logic n_one;     // set holds a single task
        logic k_is_pos;  // trial slot is the insertion point
        logic k_last;    // trial at final slot
        logic pos_last;  // final insertion point tried
        logic j_at_best; // shift reached insertion point
        logic em_last;   // final result of the sequence
    } sts_t;

endpackage

// ===== rtl/neh_insertion_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// neh_insertion_scheduler_unit
// loads a task set, orders it by neh insertion on weighted completion cost
// ----------------------------------------------------------------------------
// Tasks are taken one per transaction while busy is low (start high), so a
// set streams in at one task per cycle. The task with last set ends the set
// and starts scheduling; busy stays high until the final result is out.
// Tasks beyond MAX_TASKS are discarded and flag dropped on every result.
// Scheduling runs the stable rank sort, then for each further task an
// insertion trial at every position, a shift of the entries from the best
// position up and the insertion of the candidate, then emits the results.
// The trial loop is set by the single read port of the sequence ram
// chained into the task data rams and one shared multiplier. Results come
// out with out_valid high for exactly one cycle each and cannot be stalled
// by the receiver.
// ----------------------------------------------------------------------------
module neh_insertion_scheduler_unit #(
    parameter int MAX_TASKS  = neh_pkg::DEF_MAX_TASKS,
    parameter int VALUE_BITS = neh_pkg::DEF_VALUE_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // task input, accepted when start is high and busy is low
    input  logic                       start,
    output logic                       busy,
    input  logic [neh_pkg::DATA_W-1:0] proc_time,
    input  logic [neh_pkg::DATA_W-1:0] task_weight,
    input  logic                       last,
    // result output, one transaction per out_valid cycle
    output logic                       out_valid,
    output logic [neh_pkg::DATA_W-1:0] out_time,
    output logic [neh_pkg::DATA_W-1:0] out_weight,
    output logic                       out_last,
    output logic                       dropped
);

    neh_pkg::cmd_t cmd;
    neh_pkg::sts_t sts;

    // sequencer: one state per datapath step
    neh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (last),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // stores, counters, cost accumulator
    neh_dpath #(
        .MAX_TASKS  (MAX_TASKS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .proc_time   (proc_time),
        .task_weight (task_weight),
        .sts         (sts),
        .out_time    (out_time),
        .out_weight  (out_weight),
        .out_last    (out_last),
        .dropped     (dropped)
    );

    // result strobe comes straight from the emit step
    assign out_valid = cmd.em_out;

endmodule

// ===== rtl/neh_ram.sv =====
// ----------------------------------------------------------------------------
// neh_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module neh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/neh_ctrl.sv =====
// ----------------------------------------------------------------------------
// neh_ctrl
// sequencer for load, rank sort, insertion trials, shift and emit
// ----------------------------------------------------------------------------
module neh_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             last,
    input  neh_pkg::sts_t    sts,
    output neh_pkg::cmd_t    cmd,
    output logic             busy
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_RK_I    = 5'd1;
    localparam logic [4:0] S_RK_IW   = 5'd2;
    localparam logic [4:0] S_RK_J    = 5'd3;
    localparam logic [4:0] S_RK_JW   = 5'd4;
    localparam logic [4:0] S_RK_WR   = 5'd5;
    localparam logic [4:0] S_N0_RD   = 5'd6;
    localparam logic [4:0] S_N0_WR   = 5'd7;
    localparam logic [4:0] S_CD_RD   = 5'd8;
    localparam logic [4:0] S_CD_IDX  = 5'd9;
    localparam logic [4:0] S_CD_TW   = 5'd10;
    localparam logic [4:0] S_TR_INIT = 5'd11;
    localparam logic [4:0] S_TR_ORD  = 5'd12;
    localparam logic [4:0] S_TR_OIDX = 5'd13;
    localparam logic [4:0] S_TR_RUN  = 5'd14;
    localparam logic [4:0] S_TR_MUL  = 5'd15;
    localparam logic [4:0] S_TR_ACC  = 5'd16;
    localparam logic [4:0] S_TR_CMP  = 5'd17;
    localparam logic [4:0] S_SH_CHK  = 5'd18;
    localparam logic [4:0] S_SH_WR   = 5'd19;
    localparam logic [4:0] S_SH_INS  = 5'd20;
    localparam logic [4:0] S_EM_ORD  = 5'd21;
    localparam logic [4:0] S_EM_IDX  = 5'd22;
    localparam logic [4:0] S_EM_OUT  = 5'd23;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load      = 1'b1;
                    cmd.load_last = last;
                    if (last)
                    begin
                        state_next = S_RK_I;
                    end
                end
            end
            S_RK_I:
            begin
                cmd.rk_rd_i = 1'b1;
                state_next  = S_RK_IW;
            end
            S_RK_IW:
            begin
                cmd.rk_lat = 1'b1;
                state_next = S_RK_J;
            end
            S_RK_J:
            begin
                cmd.rk_rd_j = 1'b1;
                state_next  = S_RK_JW;
            end
            S_RK_JW:
            begin
                cmd.rk_cmp = 1'b1;
                state_next = sts.j_last ? S_RK_WR : S_RK_J;
            end
            S_RK_WR:
            begin
                cmd.rk_wr  = 1'b1;
                state_next = sts.i_last ? S_N0_RD : S_RK_I;
            end
            S_N0_RD:
            begin
                cmd.n0_rd  = 1'b1;
                state_next = S_N0_WR;
            end
            S_N0_WR:
            begin
                cmd.n0_wr  = 1'b1;
                state_next = sts.n_one ? S_EM_ORD : S_CD_RD;
            end
            S_CD_RD:
            begin
                cmd.cd_rd  = 1'b1;
                state_next = S_CD_IDX;
            end
            S_CD_IDX:
            begin
                cmd.cd_idx = 1'b1;
                state_next = S_CD_TW;
            end
            S_CD_TW:
            begin
                cmd.cd_tw  = 1'b1;
                state_next = S_TR_INIT;
            end
            S_TR_INIT:
            begin
                cmd.tr_init = 1'b1;
                state_next  = S_TR_ORD;
            end
            S_TR_ORD:
            begin
                cmd.tr_ord = 1'b1;
                state_next = sts.k_is_pos ? S_TR_RUN : S_TR_OIDX;
            end
            S_TR_OIDX:
            begin
                cmd.tr_oidx = 1'b1;
                state_next  = S_TR_RUN;
            end
            S_TR_RUN:
            begin
                cmd.tr_run = 1'b1;
                state_next = S_TR_MUL;
            end
            S_TR_MUL:
            begin
                cmd.tr_mul = 1'b1;
                state_next = S_TR_ACC;
            end
            S_TR_ACC:
            begin
                cmd.tr_acc = 1'b1;
                state_next = sts.k_last ? S_TR_CMP : S_TR_ORD;
            end
            S_TR_CMP:
            begin
                cmd.tr_cmp = 1'b1;
                state_next = sts.pos_last ? S_SH_CHK : S_TR_INIT;
            end
            S_SH_CHK:
            begin
                cmd.sh_rd  = 1'b1;
                state_next = sts.j_at_best ? S_SH_INS : S_SH_WR;
            end
            S_SH_WR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = S_SH_CHK;
            end
            S_SH_INS:
            begin
                cmd.sh_ins = 1'b1;
                state_next = sts.i_last ? S_EM_ORD : S_CD_RD;
            end
            S_EM_ORD:
            begin
                cmd.em_ord = 1'b1;
                state_next = S_EM_IDX;
            end
            S_EM_IDX:
            begin
                cmd.em_idx = 1'b1;
                state_next = S_EM_OUT;
            end
            S_EM_OUT:
            begin
                cmd.em_out = 1'b1;
                state_next = sts.em_last ? S_IDLE : S_EM_ORD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy)
        else $error("task stored while busy");
    a_emit_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.em_out && sts.em_last |=> !busy)
        else $error("block still busy after final result");
    a_start_sort: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_last |=> cmd.rk_rd_i)
        else $error("final task did not start ranking");

endmodule

// ===== rtl/neh_dpath.sv =====
// ----------------------------------------------------------------------------
// neh_dpath
// task stores, rank sort counters, trial cost datapath and output fields
// ----------------------------------------------------------------------------
module neh_dpath #(
    parameter int MAX_TASKS  = neh_pkg::DEF_MAX_TASKS,
    parameter int VALUE_BITS = neh_pkg::DEF_VALUE_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  neh_pkg::cmd_t              cmd,
    input  logic [neh_pkg::DATA_W-1:0] proc_time,
    input  logic [neh_pkg::DATA_W-1:0] task_weight,
    output neh_pkg::sts_t              sts,
    output logic [neh_pkg::DATA_W-1:0] out_time,
    output logic [neh_pkg::DATA_W-1:0] out_weight,
    output logic                       out_last,
    output logic                       dropped
);

    localparam int VB     = VALUE_BITS;
    localparam int IDX_W  = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int KEY_W  = VB + 1;
    localparam int RUN_W  = VB + CNT_W;
    localparam int PROD_W = RUN_W + VB;
    localparam int COST_W = PROD_W + CNT_W;

    // control state
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [COST_W-1:0] best_reg, best_next;

    // working registers
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  src_reg, src_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  bpos_reg, bpos_next;
    logic [CNT_W-1:0]  rank_reg, rank_next;
    logic              have_reg, have_next;
    logic              ucand_reg, ucand_next;
    logic [KEY_W-1:0]  key_i_reg, key_i_next;
    logic [IDX_W-1:0]  cidx_reg, cidx_next;
    logic [VB-1:0]     ct_reg, ct_next;
    logic [VB-1:0]     cw_reg, cw_next;
    logic [VB-1:0]     w_reg, w_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [COST_W-1:0] cost_reg, cost_next;

    // memory ports
    logic              tw_we;
    logic [IDX_W-1:0]  tw_raddr;
    logic [VB-1:0]     time_q, weight_q;
    logic              so_we;
    logic [IDX_W-1:0]  so_waddr, so_raddr;
    logic [IDX_W-1:0]  sorted_q;
    logic              or_we;
    logic [IDX_W-1:0]  or_waddr, or_wdata, or_raddr;
    logic [IDX_W-1:0]  order_q;

    logic              full;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  j_m1;
    logic [KEY_W-1:0]  key_j;
    logic [VB-1:0]     sel_t, sel_w;

    assign full   = (cnt_reg == CNT_W'(MAX_TASKS));
    assign cnt_m1 = cnt_reg - CNT_W'(1);
    assign j_m1   = j_reg - CNT_W'(1);
    assign key_j  = KEY_W'(time_q) + KEY_W'(weight_q);
    assign sel_t  = ucand_reg ? ct_reg : time_q;
    assign sel_w  = ucand_reg ? cw_reg : weight_q;

    assign sts.j_last    = (j_reg == cnt_m1);
    assign sts.i_last    = (i_reg == cnt_m1);
    assign sts.n_one     = (cnt_reg == CNT_W'(1));
    assign sts.k_is_pos  = (k_reg == pos_reg);
    assign sts.k_last    = (k_reg == len_reg);
    assign sts.pos_last  = (pos_reg == len_reg);
    assign sts.j_at_best = (j_reg == bpos_reg);
    assign sts.em_last   = (k_reg == cnt_m1);

    // memory addressing
    assign tw_we = cmd.load && !full;

    always_comb
    begin
        tw_raddr = i_reg[IDX_W-1:0];
        if (cmd.rk_rd_j)
        begin
            tw_raddr = j_reg[IDX_W-1:0];
        end
        else if (cmd.cd_idx)
        begin
            tw_raddr = sorted_q;
        end
        else if (cmd.tr_oidx || cmd.em_idx)
        begin
            tw_raddr = order_q;
        end
    end

    assign so_we    = cmd.rk_wr;
    assign so_waddr = rank_reg[IDX_W-1:0];
    assign so_raddr = cmd.n0_rd ? '0 : i_reg[IDX_W-1:0];

    always_comb
    begin
        or_we    = cmd.n0_wr || cmd.sh_wr || cmd.sh_ins;
        or_waddr = '0;
        or_wdata = sorted_q;
        if (cmd.sh_wr)
        begin
            or_waddr = j_reg[IDX_W-1:0];
            or_wdata = order_q;
        end
        else if (cmd.sh_ins)
        begin
            or_waddr = bpos_reg[IDX_W-1:0];
            or_wdata = cidx_reg;
        end
        or_raddr = src_reg[IDX_W-1:0];
        if (cmd.sh_rd)
        begin
            or_raddr = j_m1[IDX_W-1:0];
        end
        else if (cmd.em_ord)
        begin
            or_raddr = k_reg[IDX_W-1:0];
        end
    end

    neh_ram #(.WIDTH(VB), .DEPTH(MAX_TASKS)) u_time_ram (
        .clk   (clk),
        .we    (tw_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (VB'(proc_time)),
        .raddr (tw_raddr),
        .rdata (time_q)
    );

    neh_ram #(.WIDTH(VB), .DEPTH(MAX_TASKS)) u_weight_ram (
        .clk   (clk),
        .we    (tw_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (VB'(task_weight)),
        .raddr (tw_raddr),
        .rdata (weight_q)
    );

    neh_ram #(.WIDTH(IDX_W), .DEPTH(MAX_TASKS)) u_sorted_ram (
        .clk   (clk),
        .we    (so_we),
        .waddr (so_waddr),
        .wdata (i_reg[IDX_W-1:0]),
        .raddr (so_raddr),
        .rdata (sorted_q)
    );

    neh_ram #(.WIDTH(IDX_W), .DEPTH(MAX_TASKS)) u_order_ram (
        .clk   (clk),
        .we    (or_we),
        .waddr (or_waddr),
        .wdata (or_wdata),
        .raddr (or_raddr),
        .rdata (order_q)
    );

    always_comb
    begin
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        best_next  = best_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        src_next   = src_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        bpos_next  = bpos_reg;
        rank_next  = rank_reg;
        have_next  = have_reg;
        ucand_next = ucand_reg;
        key_i_next = key_i_reg;
        cidx_next  = cidx_reg;
        ct_next    = ct_reg;
        cw_next    = cw_reg;
        w_next     = w_reg;
        run_next   = run_reg;
        prod_next  = prod_reg;
        cost_next  = cost_reg;

        if (cmd.load)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            if (cmd.load_last)
            begin
                i_next = '0;
            end
        end
        // stable rank: count smaller keys and equal keys that arrived earlier
        if (cmd.rk_lat)
        begin
            key_i_next = key_j;
            j_next     = '0;
            rank_next  = '0;
        end
        if (cmd.rk_cmp)
        begin
            if ((key_j < key_i_reg) || ((key_j == key_i_reg) && (j_reg < i_reg)))
            begin
                rank_next = rank_reg + CNT_W'(1);
            end
            j_next = j_reg + CNT_W'(1);
        end
        if (cmd.rk_wr)
        begin
            i_next = i_reg + CNT_W'(1);
        end
        if (cmd.n0_wr)
        begin
            len_next = CNT_W'(1);
            i_next   = CNT_W'(1);
            k_next   = '0;
        end
        if (cmd.cd_idx)
        begin
            cidx_next = sorted_q;
        end
        if (cmd.cd_tw)
        begin
            ct_next   = time_q;
            cw_next   = weight_q;
            pos_next  = '0;
            have_next = 1'b0;
        end
        if (cmd.tr_init)
        begin
            k_next    = '0;
            src_next  = '0;
            run_next  = '0;
            cost_next = '0;
        end
        if (cmd.tr_ord)
        begin
            ucand_next = (k_reg == pos_reg);
        end
        if (cmd.tr_oidx)
        begin
            src_next = src_reg + CNT_W'(1);
        end
        if (cmd.tr_run)
        begin
            run_next = run_reg + RUN_W'(sel_t);
            w_next   = sel_w;
        end
        if (cmd.tr_mul)
        begin
            prod_next = PROD_W'(run_reg) * PROD_W'(w_reg);
        end
        if (cmd.tr_acc)
        begin
            cost_next = cost_reg + COST_W'(prod_reg);
            k_next    = k_reg + CNT_W'(1);
        end
        // first position with strictly least cost wins
        if (cmd.tr_cmp)
        begin
            if (!have_reg || (cost_reg < best_reg))
            begin
                best_next = cost_reg;
                bpos_next = pos_reg;
                have_next = 1'b1;
            end
            pos_next = pos_reg + CNT_W'(1);
            j_next   = len_reg;
        end
        if (cmd.sh_wr)
        begin
            j_next = j_m1;
        end
        if (cmd.sh_ins)
        begin
            len_next = len_reg + CNT_W'(1);
            i_next   = i_reg + CNT_W'(1);
            k_next   = '0;
        end
        if (cmd.em_out)
        begin
            k_next = k_reg + CNT_W'(1);
            if (sts.em_last)
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            best_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            best_reg <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        src_reg   <= src_next;
        len_reg   <= len_next;
        pos_reg   <= pos_next;
        bpos_reg  <= bpos_next;
        rank_reg  <= rank_next;
        have_reg  <= have_next;
        ucand_reg <= ucand_next;
        key_i_reg <= key_i_next;
        cidx_reg  <= cidx_next;
        ct_reg    <= ct_next;
        cw_reg    <= cw_next;
        w_reg     <= w_next;
        run_reg   <= run_next;
        prod_reg  <= prod_next;
        cost_reg  <= cost_next;
    end

    assign out_time   = neh_pkg::DATA_W'(time_q);
    assign out_weight = neh_pkg::DATA_W'(weight_q);
    assign out_last   = sts.em_last;
    assign dropped    = ovf_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_TASKS))
        else $error("task count beyond capacity");
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.em_out && sts.em_last |=> (cnt_reg == '0) && !ovf_reg)
        else $error("set state not cleared after final result");
    a_ins_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sh_ins |-> (bpos_reg <= len_reg) && have_reg)
        else $error("insertion point outside sequence");

endmodule
